### src/tphp_pkg.sv
// Shared types, codes and limits for the TLS post-handshake parser.
package tphp_pkg;

	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 120;
	localparam int unsigned OUT_TUSER_W = 4;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [23:0] MAX_MESSAGE_LEN = 24'd16384;
	localparam logic [7:0]  MAX_NONCE_LEN   = 8'd32;
	localparam logic [47:0] EPOCH_CAP       = 48'hffff_ffff_ffff;
	localparam logic [2:0]  HDR_BYTES       = 3'd4;

	localparam logic [7:0] TYPE_TICKET     = 8'd4;
	localparam logic [7:0] TYPE_KEY_UPDATE = 8'd24;

	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_SIZE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDENTITY_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SINK_ENABLED   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SESSION_EPOCH  = 2'd3;

	localparam logic [3:0] ROLE_HEADER   = 4'd0;
	localparam logic [3:0] ROLE_LIFETIME = 4'd1;
	localparam logic [3:0] ROLE_AGE_ADD  = 4'd2;
	localparam logic [3:0] ROLE_NONCE_LEN = 4'd3;
	localparam logic [3:0] ROLE_NONCE    = 4'd4;
	localparam logic [3:0] ROLE_ID_LEN   = 4'd5;
	localparam logic [3:0] ROLE_IDENTITY = 4'd6;
	localparam logic [3:0] ROLE_REST     = 4'd7;
	localparam logic [3:0] ROLE_KEY_UPD  = 4'd8;

	localparam logic [2:0] EV_NONE        = 3'd0;
	localparam logic [2:0] EV_TICKET_OK   = 3'd1;
	localparam logic [2:0] EV_TICKET_SKIP = 3'd2;
	localparam logic [2:0] EV_REKEY       = 3'd3;
	localparam logic [2:0] EV_REKEY_REPLY = 3'd4;
	localparam logic [2:0] EV_PROTO_ERR   = 3'd5;

	localparam logic [3:0] PH_LIFE  = 4'd0;
	localparam logic [3:0] PH_AGE   = 4'd1;
	localparam logic [3:0] PH_NLEN  = 4'd2;
	localparam logic [3:0] PH_NONCE = 4'd3;
	localparam logic [3:0] PH_IDLEN = 4'd4;
	localparam logic [3:0] PH_ID    = 4'd5;
	localparam logic [3:0] PH_REST  = 4'd6;

	typedef struct packed {
		logic [5:0]  pad;
		logic        error_latched;
		logic [15:0] ticket_epoch;
		logic [15:0] ticket_identity_len;
		logic [5:0]  ticket_nonce_len;
		logic [31:0] ticket_age_add;
		logic [31:0] ticket_lifetime;
		logic [2:0]  event_code;
		logic [7:0]  byte_echo;
	} result_t;

endpackage

### src/tls_post_handshake_parser_core.sv
// Top level: byte-serial TLS 1.3 post-handshake message parser.
// Takes one plaintext byte per clock and returns one tagged result per byte, in the cycle after
// the transfer. The state update and result decode for a byte sit between the input handshake
// and a single result register, so a byte is accepted every cycle while the result register
// is empty or being drained; a stalled sink holds the result register and with it the input.
// Configuration writes complete in the cycle they are presented.
module tls_post_handshake_parser_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [tphp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // data_byte
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// byte_echo, event_code, ticket_lifetime, ticket_age_add, ticket_nonce_len,
	// ticket_identity_len, ticket_epoch, error_latched, zero pad
	output logic [tphp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	output logic [tphp_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,  // byte_role
	output logic                               m_axis_tlast,  // message_end
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tphp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tphp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tphp_pkg::*;

	logic [15:0] buffer_size_q, identity_limit_q, session_epoch_q;
	logic        sink_en_q;

	logic [2:0]  hdr_cnt_q, hdr_cnt_d;
	logic [7:0]  msg_type_q, msg_type_d;
	logic [23:0] msg_len_q, msg_len_d;
	logic [14:0] body_off_q, body_off_d;
	logic [3:0]  phase_q, phase_d;
	logic [15:0] field_rem_q, field_rem_d, rem_dec;
	logic [31:0] life_q, life_d, age_q, age_d;
	logic [7:0]  nonce_len_q, nonce_len_d;
	logic [15:0] id_len_q, id_len_d;
	logic        underrun_q, underrun_d;
	logic        error_q, error_d;
	logic [47:0] epoch_cnt_q, epoch_cnt_d;

	logic        out_valid_q;
	result_t     res_q, res_d;
	logic [3:0]  role_q, role_d;
	logic        mend_q, mend_d;

	logic [7:0]  b;
	logic        accept, fin, too_long;
	logic [24:0] len_total;

	assign b             = s_axis_tdata;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign rem_dec       = field_rem_q - 16'd1;
	assign len_total     = {1'b0, msg_len_d} + 25'd4;
	assign too_long      = (msg_len_d > MAX_MESSAGE_LEN) || (len_total > {9'd0, buffer_size_q});

	always_comb begin
		hdr_cnt_d   = hdr_cnt_q;
		msg_type_d  = msg_type_q;
		msg_len_d   = msg_len_q;
		body_off_d  = body_off_q;
		phase_d     = phase_q;
		field_rem_d = field_rem_q;
		life_d      = life_q;
		age_d       = age_q;
		nonce_len_d = nonce_len_q;
		id_len_d    = id_len_q;
		underrun_d  = underrun_q;
		error_d     = error_q;
		epoch_cnt_d = epoch_cnt_q;
		fin         = 1'b0;
		role_d      = ROLE_HEADER;
		mend_d      = 1'b0;
		res_d       = '0;
		res_d.byte_echo = b;

		if (!error_q) begin
			if (hdr_cnt_q != HDR_BYTES) begin
				if (hdr_cnt_q == 3'd0) begin
					msg_type_d = b;
					msg_len_d  = '0;
				end else begin
					msg_len_d = {msg_len_q[15:0], b};
				end
				hdr_cnt_d = hdr_cnt_q + 3'd1;
				if (hdr_cnt_q == 3'd3) begin
					if (too_long) begin
						error_d          = 1'b1;
						res_d.event_code = EV_PROTO_ERR;
						hdr_cnt_d        = '0;
					end else begin
						body_off_d  = '0;
						phase_d     = PH_LIFE;
						field_rem_d = 16'd4;
						life_d      = '0;
						age_d       = '0;
						nonce_len_d = '0;
						id_len_d    = '0;
						underrun_d  = 1'b0;
						fin         = (msg_len_d == 24'd0);
					end
				end
			end else begin
				if (msg_type_q == TYPE_TICKET) begin
					case (phase_q)
						PH_LIFE: begin
							role_d      = ROLE_LIFETIME;
							life_d      = {life_q[23:0], b};
							field_rem_d = rem_dec;
							if (rem_dec == 16'd0) begin
								phase_d     = PH_AGE;
								field_rem_d = 16'd4;
							end
						end
						PH_AGE: begin
							role_d      = ROLE_AGE_ADD;
							age_d       = {age_q[23:0], b};
							field_rem_d = rem_dec;
							if (rem_dec == 16'd0) begin
								phase_d     = PH_NLEN;
								field_rem_d = 16'd1;
							end
						end
						PH_NLEN: begin
							role_d      = ROLE_NONCE_LEN;
							nonce_len_d = b;
							if (b == 8'd0) begin
								phase_d     = PH_IDLEN;
								field_rem_d = 16'd2;
							end else begin
								phase_d     = PH_NONCE;
								field_rem_d = {8'd0, b};
							end
						end
						PH_NONCE: begin
							role_d      = ROLE_NONCE;
							field_rem_d = rem_dec;
							if (rem_dec == 16'd0) begin
								phase_d     = PH_IDLEN;
								field_rem_d = 16'd2;
							end
						end
						PH_IDLEN: begin
							role_d      = ROLE_ID_LEN;
							id_len_d    = {id_len_q[7:0], b};
							field_rem_d = rem_dec;
							if (rem_dec == 16'd0) begin
								if (id_len_d == 16'd0) begin
									phase_d = PH_REST;
								end else begin
									phase_d     = PH_ID;
									field_rem_d = id_len_d;
								end
							end
						end
						PH_ID: begin
							role_d      = ROLE_IDENTITY;
							field_rem_d = rem_dec;
							if (rem_dec == 16'd0) begin
								phase_d = PH_REST;
							end
						end
						default: begin
							role_d = ROLE_REST;
						end
					endcase
				end else if (msg_type_q == TYPE_KEY_UPDATE) begin
					role_d = ROLE_KEY_UPD;
					if (body_off_q == 15'd0) begin
						life_d = {24'd0, b};
					end
				end else begin
					role_d = ROLE_REST;
				end
				body_off_d = body_off_q + 15'd1;
				fin        = ({9'd0, body_off_d} >= msg_len_q);
			end

			if (fin) begin
				hdr_cnt_d = '0;
				if (msg_type_d == TYPE_TICKET) begin
					underrun_d = (phase_d != PH_REST);
					if (underrun_d || !sink_en_q || nonce_len_d > MAX_NONCE_LEN
							|| id_len_d > identity_limit_q) begin
						res_d.event_code = EV_TICKET_SKIP;
					end else begin
						res_d.event_code          = EV_TICKET_OK;
						res_d.ticket_lifetime     = life_d;
						res_d.ticket_age_add      = age_d;
						res_d.ticket_nonce_len    = nonce_len_d[5:0];
						res_d.ticket_identity_len = id_len_d;
						res_d.ticket_epoch        = session_epoch_q;
					end
					mend_d = 1'b1;
				end else if (msg_type_d == TYPE_KEY_UPDATE && msg_len_d == 24'd1
						&& life_d[7:0] <= 8'd1) begin
					if (life_d[7:0] == 8'd1 && epoch_cnt_q != EPOCH_CAP) begin
						epoch_cnt_d      = epoch_cnt_q + 48'd1;
						res_d.event_code = EV_REKEY_REPLY;
					end else begin
						res_d.event_code = EV_REKEY;
					end
					mend_d = 1'b1;
				end else begin
					error_d          = 1'b1;
					res_d.event_code = EV_PROTO_ERR;
				end
			end
		end
		res_d.error_latched = error_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q    <= 16'd16388;
			identity_limit_q <= 16'd1024;
			sink_en_q        <= 1'b0;
			session_epoch_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BUFFER_SIZE:    buffer_size_q    <= cfg_data;
				REG_IDENTITY_LIMIT: identity_limit_q <= cfg_data;
				REG_SINK_ENABLED:   sink_en_q        <= cfg_data[0];
				REG_SESSION_EPOCH:  session_epoch_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q   <= '0;
			msg_type_q  <= '0;
			msg_len_q   <= '0;
			body_off_q  <= '0;
			phase_q     <= '0;
			field_rem_q <= '0;
			life_q      <= '0;
			age_q       <= '0;
			nonce_len_q <= '0;
			id_len_q    <= '0;
			underrun_q  <= 1'b0;
			error_q     <= 1'b0;
			epoch_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				hdr_cnt_q   <= hdr_cnt_d;
				msg_type_q  <= msg_type_d;
				msg_len_q   <= msg_len_d;
				body_off_q  <= body_off_d;
				phase_q     <= phase_d;
				field_rem_q <= field_rem_d;
				life_q      <= life_d;
				age_q       <= age_d;
				nonce_len_q <= nonce_len_d;
				id_len_q    <= id_len_d;
				underrun_q  <= underrun_d;
				error_q     <= error_d;
				epoch_cnt_q <= epoch_cnt_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q  <= res_d;
			role_q <= role_d;
			mend_q <= mend_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = res_q;
	assign m_axis_tuser  = role_q;
	assign m_axis_tlast  = mend_q;

endmodule

### src/tphp_chk.sv
// Port checker for the TLS post-handshake parser, bound to the top level.
module tphp_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [tphp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input logic [tphp_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
	input logic                               m_axis_tlast
);
	import tphp_pkg::*;

	result_t res;
	logic    xfer;
	logic    err_seen_q;

	assign res  = m_axis_tdata;
	assign xfer = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
		end else if (xfer && res.error_latched) begin
			err_seen_q <= 1'b1;
		end
	end

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && err_seen_q |-> res.error_latched && res.event_code == EV_NONE
			&& m_axis_tuser == ROLE_HEADER && !m_axis_tlast)
		else $error("error flag dropped or output active after protocol error");

	a_proto_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.event_code == EV_PROTO_ERR |-> res.error_latched && !m_axis_tlast)
		else $error("protocol error without latched flag or with message end");

	a_ticket_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.event_code != EV_TICKET_OK |->
			res.ticket_lifetime == 32'd0 && res.ticket_age_add == 32'd0
			&& res.ticket_identity_len == 16'd0 && res.ticket_epoch == 16'd0)
		else $error("ticket fields set without accepted ticket");

	a_end_event: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |->
			res.event_code == EV_TICKET_OK || res.event_code == EV_TICKET_SKIP
			|| res.event_code == EV_REKEY || res.event_code == EV_REKEY_REPLY)
		else $error("message end without completion event");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind tls_post_handshake_parser_core tphp_chk u_tphp_chk (.*);

### verif/tphp_result_checker.sv
// Result checker for the TLS post-handshake parser: predicts every byte result and compares.
module tphp_result_checker
	import tphp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic [OUT_TUSER_W-1:0] m_axis_tuser,
	input  logic                   m_axis_tlast,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     failures,
	output int                     outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [3:0]  role;
		logic [7:0]  echo;
		logic [2:0]  ev;
		logic [31:0] lifetime;
		logic [31:0] age_add;
		logic [5:0]  nonce_bytes;
		logic [15:0] id_len;
		logic [15:0] epoch;
		logic        last;
		logic        err;
	} parsed_byte_t;

	logic [15:0] buf_size, id_limit, sess_epoch;
	logic        sink_on;

	logic [2:0]  hdr_cnt;
	logic [7:0]  msg_kind;
	logic [23:0] msg_len;
	logic [23:0] body_off;
	logic [3:0]  phase;
	logic [15:0] remaining;
	logic [31:0] life_acc, age_acc;
	logic [7:0]  nonce_acc;
	logic [15:0] id_acc;
	logic        err_flag;
	logic [47:0] reply_count;

	parsed_byte_t expected_bytes [$];
	parsed_byte_t predicted, oldest;

	task automatic close_message(inout parsed_byte_t r);
		hdr_cnt = '0;
		if (msg_kind == TYPE_TICKET) begin
			if (phase != PH_REST || !sink_on || nonce_acc > MAX_NONCE_LEN || id_acc > id_limit) begin
				r.ev = EV_TICKET_SKIP;
			end else begin
				r.ev          = EV_TICKET_OK;
				r.lifetime    = life_acc;
				r.age_add     = age_acc;
				r.nonce_bytes = nonce_acc[5:0];
				r.id_len      = id_acc;
				r.epoch       = sess_epoch;
			end
			r.last = 1'b1;
		end else if (msg_kind == TYPE_KEY_UPDATE && msg_len == 24'd1 && life_acc[7:0] <= 8'd1) begin
			if (life_acc[7:0] == 8'd1 && reply_count < EPOCH_CAP) begin
				reply_count = reply_count + 48'd1;
				r.ev = EV_REKEY_REPLY;
			end else begin
				r.ev = EV_REKEY;
			end
			r.last = 1'b1;
		end else begin
			err_flag = 1'b1;
			r.ev = EV_PROTO_ERR;
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, output parsed_byte_t r);
		r = '0;
		r.echo = b;
		if (!err_flag) begin
			if (hdr_cnt < HDR_BYTES) begin
				r.role = ROLE_HEADER;
				if (hdr_cnt == 3'd0) begin
					msg_kind = b;
					msg_len  = '0;
				end else begin
					msg_len = {msg_len[15:0], b};
				end
				hdr_cnt = hdr_cnt + 3'd1;
				if (hdr_cnt == HDR_BYTES) begin
					if (msg_len > MAX_MESSAGE_LEN ||
					    {8'd0, msg_len} + 32'd4 > {16'd0, buf_size}) begin
						err_flag = 1'b1;
						r.ev = EV_PROTO_ERR;
						hdr_cnt = '0;
					end else begin
						body_off  = '0;
						phase     = PH_LIFE;
						remaining = 16'd4;
						life_acc  = '0;
						age_acc   = '0;
						nonce_acc = '0;
						id_acc    = '0;
						if (msg_len == 24'd0)
							close_message(r);
					end
				end
			end else begin
				if (msg_kind == TYPE_TICKET) begin
					case (phase)
						PH_LIFE: begin
							r.role = ROLE_LIFETIME;
							life_acc = {life_acc[23:0], b};
							remaining = remaining - 16'd1;
							if (remaining == 16'd0) begin
								phase = PH_AGE;
								remaining = 16'd4;
							end
						end
						PH_AGE: begin
							r.role = ROLE_AGE_ADD;
							age_acc = {age_acc[23:0], b};
							remaining = remaining - 16'd1;
							if (remaining == 16'd0) begin
								phase = PH_NLEN;
								remaining = 16'd1;
							end
						end
						PH_NLEN: begin
							r.role = ROLE_NONCE_LEN;
							nonce_acc = b;
							if (b == 8'd0) begin
								phase = PH_IDLEN;
								remaining = 16'd2;
							end else begin
								phase = PH_NONCE;
								remaining = {8'd0, b};
							end
						end
						PH_NONCE: begin
							r.role = ROLE_NONCE;
							remaining = remaining - 16'd1;
							if (remaining == 16'd0) begin
								phase = PH_IDLEN;
								remaining = 16'd2;
							end
						end
						PH_IDLEN: begin
							r.role = ROLE_ID_LEN;
							id_acc = {id_acc[7:0], b};
							remaining = remaining - 16'd1;
							if (remaining == 16'd0) begin
								if (id_acc == 16'd0) begin
									phase = PH_REST;
								end else begin
									phase = PH_ID;
									remaining = id_acc;
								end
							end
						end
						PH_ID: begin
							r.role = ROLE_IDENTITY;
							remaining = remaining - 16'd1;
							if (remaining == 16'd0)
								phase = PH_REST;
						end
						default: begin
							r.role = ROLE_REST;
						end
					endcase
				end else if (msg_kind == TYPE_KEY_UPDATE) begin
					r.role = ROLE_KEY_UPD;
					if (body_off == 24'd0)
						life_acc = {24'd0, b};
				end else begin
					r.role = ROLE_REST;
				end
				body_off = body_off + 24'd1;
				if (body_off >= msg_len)
					close_message(r);
			end
		end
		r.err = err_flag;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_size    = 16'd16388;
			id_limit    = 16'd1024;
			sink_on     = 1'b0;
			sess_epoch  = '0;
			hdr_cnt     = '0;
			msg_kind    = '0;
			msg_len     = '0;
			body_off    = '0;
			phase       = PH_LIFE;
			remaining   = '0;
			life_acc    = '0;
			age_acc     = '0;
			nonce_acc   = '0;
			id_acc      = '0;
			err_flag    = 1'b0;
			reply_count = '0;
			expected_bytes.delete();
			failures    = 0;
			outstanding = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_bytes.size() == 0) begin
					$error("result transfer with no byte outstanding");
					failures++;
				end else begin
					oldest = expected_bytes.pop_front();
					check_field("byte_role", oldest.role, m_axis_tuser);
					check_field("message_end", oldest.last, m_axis_tlast);
					check_field("byte_echo", oldest.echo, m_axis_tdata[7:0]);
					check_field("event_code", oldest.ev, m_axis_tdata[10:8]);
					check_field("ticket_lifetime", oldest.lifetime, m_axis_tdata[42:11]);
					check_field("ticket_age_add", oldest.age_add, m_axis_tdata[74:43]);
					check_field("ticket_nonce_len", oldest.nonce_bytes, m_axis_tdata[80:75]);
					check_field("ticket_identity_len", oldest.id_len, m_axis_tdata[96:81]);
					check_field("ticket_epoch", oldest.epoch, m_axis_tdata[112:97]);
					check_field("error_latched", oldest.err, m_axis_tdata[113]);
					check_field("pad", 32'd0, m_axis_tdata[119:114]);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BUFFER_SIZE:    buf_size   = cfg_data;
					REG_IDENTITY_LIMIT: id_limit   = cfg_data;
					REG_SINK_ENABLED:   sink_on    = cfg_data[0];
					REG_SESSION_EPOCH:  sess_epoch = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				parse_byte(s_axis_tdata, predicted);
				expected_bytes.push_back(predicted);
			end
			outstanding = expected_bytes.size();
		end
	end

endmodule

### verif/tls_post_handshake_parser_core_tb.sv
// Testbench top for the TLS post-handshake parser: message stimulus, configuration and verdict.
module tls_post_handshake_parser_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tphp_pkg::*;

	localparam int PHASE_ITEMS = 150;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   m_axis_tready = 1'b0;
	logic                   cfg_valid     = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index     = REG_BUFFER_SIZE;
	logic [CFG_DATA_W-1:0]  cfg_data      = '0;
	logic                   s_axis_tready;
	logic                   m_axis_tvalid;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;
	logic                   m_axis_tlast;
	logic                   cfg_ready;
	int                     failures;
	int                     outstanding;

	logic        tx_steady = 1'b0;
	logic        rx_steady = 1'b0;
	int          cur_buf   = 16388;
	int          cur_idlim = 1024;
	int          sent_bytes = 0;
	logic [7:0]  msg_body [$];

	always #5 clk = ~clk;

	tls_post_handshake_parser_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	tphp_result_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.failures      (failures),
		.outstanding   (outstanding)
	);

	always @(negedge clk)
		m_axis_tready <= rx_steady || ($urandom_range(99) >= 22);

	task automatic push_byte(input logic [7:0] value);
		while (!tx_steady && $urandom_range(99) < 22) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		sent_bytes++;
	endtask

	task automatic send_header(input logic [7:0] msg_kind, input logic [23:0] len);
		push_byte(msg_kind);
		push_byte(len[23:16]);
		push_byte(len[15:8]);
		push_byte(len[7:0]);
	endtask

	task automatic send_message(input logic [7:0] msg_kind);
		int cap;
		logic [7:0] kind_sent;
		cap = (cur_buf - 4 < 16384) ? cur_buf - 4 : 16384;
		kind_sent = msg_kind;
		while (msg_body.size() > cap)
			void'(msg_body.pop_back());
		if (kind_sent == TYPE_KEY_UPDATE && msg_body.size() == 0)
			kind_sent = TYPE_TICKET;
		send_header(kind_sent, 24'(msg_body.size()));
		foreach (msg_body[i])
			push_byte(msg_body[i]);
	endtask

	function automatic logic [7:0] fill_byte(input int fill);
		return (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
	endfunction

	task automatic build_ticket(input int nlen, input int idlen, input int rest, input int fill);
		msg_body.delete();
		repeat (8) msg_body.push_back(fill_byte(fill));
		msg_body.push_back(8'(nlen));
		repeat (nlen) msg_body.push_back(fill_byte(fill));
		msg_body.push_back(8'(idlen >> 8));
		msg_body.push_back(8'(idlen));
		repeat (idlen) msg_body.push_back(fill_byte(fill));
		repeat (rest) msg_body.push_back(fill_byte(fill));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic write_config(input int buf_sz, input int id_lim, input logic sink,
	                            input logic [15:0] epoch);
		drain();
		write_reg(REG_BUFFER_SIZE, 16'(buf_sz));
		write_reg(REG_IDENTITY_LIMIT, 16'(id_lim));
		write_reg(REG_SINK_ENABLED, {15'd0, sink});
		write_reg(REG_SESSION_EPOCH, epoch);
		cfg_valid <= 1'b0;
		cur_buf   = buf_sz;
		cur_idlim = id_lim;
	endtask

	task automatic random_traffic(input int count);
		int target, sel, pick, nlen, idlen, cut;
		target = sent_bytes + count;
		while (sent_bytes < target) begin
			sel = $urandom_range(99);
			if (sel < 20) begin
				msg_body.delete();
				msg_body.push_back(8'($urandom_range(1)));
				send_message(TYPE_KEY_UPDATE);
			end else if (sel < 28) begin
				msg_body.delete();
				send_message(TYPE_TICKET);
			end else begin
				pick = $urandom_range(99);
				if (pick < 70)
					nlen = $urandom_range(8);
				else if (pick < 88)
					nlen = $urandom_range(34, 30);
				else if (pick < 97)
					nlen = $urandom_range(32);
				else
					nlen = 255;
				pick = $urandom_range(99);
				if (pick < 75)
					idlen = $urandom_range(12);
				else if (cur_idlim <= 200)
					idlen = $urandom_range(cur_idlim + 2, (cur_idlim > 2) ? cur_idlim - 2 : 0);
				else
					idlen = $urandom_range(200, 13);
				build_ticket(nlen, idlen, $urandom_range(6), -1);
				if (sel < 45) begin
					cut = $urandom_range(msg_body.size(), 1);
					repeat (cut) void'(msg_body.pop_back());
				end
				send_message(TYPE_TICKET);
			end
		end
	endtask

	initial begin
		#2ms;
		$display("FAIL tls_post_handshake_parser_core");
		$finish;
	end

	initial begin
		logic [7:0] bad_kind;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		msg_body.delete();
		send_message(TYPE_TICKET);
		build_ticket(0, 0, 0, 0);
		send_message(TYPE_TICKET);
		msg_body = '{8'd0};
		send_message(TYPE_KEY_UPDATE);
		msg_body = '{8'd1};
		send_message(TYPE_KEY_UPDATE);

		write_config(65535, 65535, 1'b1, 16'hffff);
		build_ticket(32, 1, 1, 255);
		send_message(TYPE_TICKET);
		build_ticket(33, 0, 0, -1);
		send_message(TYPE_TICKET);
		build_ticket(0, 0, 0, 0);
		send_message(TYPE_TICKET);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		random_traffic(PHASE_ITEMS);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		build_ticket(0, 300, 0, -1);
		send_message(TYPE_TICKET);

		write_config(16388, 0, 1'b1, 16'($urandom()));
		random_traffic(PHASE_ITEMS / 2);
		drain();
		random_traffic(PHASE_ITEMS / 2);

		write_config($urandom_range(2000, 100), $urandom_range(40), 1'($urandom_range(1)),
		             16'($urandom()));
		random_traffic(PHASE_ITEMS);

		write_config(4, 1024, 1'b1, 16'd0);
		random_traffic(40);

		write_config(20, 8, 1'b1, 16'($urandom()));
		random_traffic(PHASE_ITEMS);

		write_config($urandom_range(2000, 100), 1024, 1'b1, 16'($urandom()));
		random_traffic(PHASE_ITEMS - 30);

		case ($urandom_range(3))
			0: send_header(8'($urandom_range(255)), 24'($urandom_range(24'hffffff, 16385)));
			1: send_header(TYPE_TICKET, 24'($urandom_range(16384, cur_buf - 3)));
			2: begin
				do bad_kind = 8'($urandom_range(255));
				while (bad_kind == TYPE_TICKET || bad_kind == TYPE_KEY_UPDATE);
				msg_body.delete();
				repeat ($urandom_range(5)) msg_body.push_back(8'($urandom_range(255)));
				send_message(bad_kind);
			end
			default: begin
				msg_body.delete();
				if ($urandom_range(1))
					msg_body.push_back(8'($urandom_range(255, 2)));
				else
					repeat ($urandom_range(5, 2)) msg_body.push_back(8'($urandom_range(255)));
				send_message(TYPE_KEY_UPDATE);
			end
		endcase
		repeat (16) push_byte(8'($urandom_range(255)));

		drain();
		repeat (8) @(negedge clk);
		if (failures == 0)
			$display("PASS tls_post_handshake_parser_core");
		else
			$display("FAIL tls_post_handshake_parser_core");
		$finish;
	end

endmodule

### filelist.f
src/tphp_pkg.sv
src/tls_post_handshake_parser_core.sv
src/tphp_chk.sv
verif/tphp_result_checker.sv
verif/tls_post_handshake_parser_core_tb.sv
